// ----- rtl/phf_pkg.sv -----
// ----------------------------------------------------------------------------
// Prefetch history filter package
// Shared widths, register codes, request codes, controller states and the
// probe word that travels along the cell chain.
// ----------------------------------------------------------------------------
package phf_pkg;

  localparam int unsigned PHF_HISTORY_DEPTH = 16;
  localparam int unsigned ADDR_W            = 32;
  localparam int unsigned ENTRIES_W         = 5;
  localparam int unsigned OFFSET_W          = 4;
  localparam int unsigned CFG_INDEX_W       = 4;
  localparam int unsigned CFG_DATA_W        = 32;

  localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = ENTRIES_W'(16);
  localparam logic [OFFSET_W-1:0]  OFFSET_RESET  = OFFSET_W'(6);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ENTRIES_IN_USE    = CFG_INDEX_W'(0),
    CFG_BLOCK_OFFSET_BITS = CFG_INDEX_W'(1)
  } cfg_reg_e;

  typedef enum logic {
    REQ_CHECK  = 1'b0,
    REQ_RECORD = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_LAUNCH,
    ST_WALK,
    ST_HOLD
  } phf_state_e;

  typedef struct packed {
    logic valid;
    logic match;
  } probe_t;

  function automatic logic [ADDR_W-1:0] block_mask(input logic [OFFSET_W-1:0] off);
    return {ADDR_W{1'b1}} << off;
  endfunction

endpackage

// ----- rtl/phf_if.sv -----
// ----------------------------------------------------------------------------
// Prefetch history filter channels
// Request, response and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface phf_req_if;
  import phf_pkg::*;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [ADDR_W-1:0] address;
  logic              target_is_cache;

  modport source (output valid, req_type, address, target_is_cache, input ready);
  modport sink   (input valid, req_type, address, target_is_cache, output ready);
endinterface

interface phf_rsp_if;
  logic valid;
  logic ready;
  logic redundant;

  modport source (output valid, redundant, input ready);
  modport sink   (input valid, redundant, output ready);
endinterface

interface phf_cfg_if;
  import phf_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/phf_cell.sv -----
// ----------------------------------------------------------------------------
// Prefetch history filter cell
// Holds one history slot, compares its block address against the request
// and passes the accumulated match to the next cell every cycle.
// ----------------------------------------------------------------------------
module phf_cell import phf_pkg::*; #(
  parameter int unsigned IW    = 4,
  parameter int unsigned INDEX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [IW-1:0]     wr_slot_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [ADDR_W-1:0] mask_i,
  input  logic              cmp_en_i,
  input  probe_t            probe_i,
  output probe_t            probe_o
);

  logic [ADDR_W-1:0] entry_q;
  probe_t            probe_q, probe_d;
  logic              hit;

  assign hit = cmp_en_i && ((entry_q & mask_i) == (addr_i & mask_i));

  always_comb begin
    probe_d.valid = probe_i.valid;
    probe_d.match = probe_i.match | hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
      if (wr_en_i && (wr_slot_i == IW'(INDEX))) begin
        entry_q <= addr_i;
      end
    end
  end

  assign probe_o = probe_q;

endmodule

// ----- rtl/prefetch_history_filter_unit.sv -----
// ----------------------------------------------------------------------------
// Prefetch history filter unit
// Ring of recent prefetch addresses with a block-address redundancy check.
// ----------------------------------------------------------------------------
// One request word is handled at a time. A check walks a probe down a chain
// of HISTORY_DEPTH cells, one cell per cycle, and its response word is
// loaded into the output register once the probe leaves the last cell and
// that register is free. A record first reduces the next slot index modulo
// the size in use by repeated subtraction, at most HISTORY_DEPTH of them,
// then writes the history slot and takes the same walk, answering not
// redundant; with no entries in use it skips the reduction and the write.
// A new request is taken as soon as the response is parked in the output
// register, even while that response is still unclaimed.
module prefetch_history_filter_unit import phf_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = PHF_HISTORY_DEPTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  phf_cfg_if.sink   cfg_i,
  phf_req_if.sink   req_i,
  phf_rsp_if.source rsp_o
);

  localparam int unsigned IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned SW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned CW = (SW > ENTRIES_W) ? SW : ENTRIES_W;

  logic [ENTRIES_W-1:0] entries_q;
  logic [OFFSET_W-1:0]  offset_q;

  phf_state_e        state_q, state_d;
  logic              req_q;
  logic [ADDR_W-1:0] addr_q;
  logic              cache_q;
  logic [SW-1:0]     rem_q, rem_d;
  logic [IW-1:0]     last_q;
  logic              last_valid_q;
  logic              out_valid_q;
  logic              out_red_q;
  logic              hold_red_q;

  logic [CW-1:0]     size_cw;
  logic [SW-1:0]     size;
  logic              accept;
  logic              launch;
  logic              wr_en;
  logic              done;
  logic              out_free;
  logic              load_out;
  logic              load_hold;
  logic              check_cache;
  logic [ADDR_W-1:0] mask;

  probe_t                   chain [HISTORY_DEPTH+1];
  logic [HISTORY_DEPTH-1:0] probe_valid;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= ENTRIES_RESET;
      offset_q  <= OFFSET_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_ENTRIES_IN_USE:    entries_q <= cfg_i.data[ENTRIES_W-1:0];
        CFG_BLOCK_OFFSET_BITS: offset_q  <= cfg_i.data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  assign size_cw = (CW'(entries_q) > CW'(HISTORY_DEPTH)) ? CW'(HISTORY_DEPTH)
                                                         : CW'(entries_q);
  assign size    = size_cw[SW-1:0];

  // control
  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign wr_en       = (state_q == ST_REDUCE) && (rem_q < size);
  assign launch      = (state_q == ST_LAUNCH);
  assign done        = chain[HISTORY_DEPTH].valid;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign load_out    = ((state_q == ST_WALK) && done && out_free) ||
                       ((state_q == ST_HOLD) && out_free);
  assign load_hold   = (state_q == ST_WALK) && done && !out_free;
  assign check_cache = (req_q == REQ_CHECK) && cache_q;
  assign mask        = block_mask(offset_q);

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rem_d = last_valid_q ? (SW'(last_q) + SW'(1)) : '0;
          if ((req_i.req_type == REQ_RECORD) && (size != '0)) begin
            state_d = ST_REDUCE;
          end else begin
            state_d = ST_LAUNCH;
          end
        end
      end
      ST_REDUCE: begin
        if (rem_q < size) begin
          state_d = ST_LAUNCH;
        end else begin
          rem_d = rem_q - size;
        end
      end
      ST_LAUNCH: state_d = ST_WALK;
      ST_WALK: begin
        if (done) begin
          state_d = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      last_valid_q <= 1'b0;
      last_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        last_q       <= rem_q[IW-1:0];
        last_valid_q <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    if (accept) begin
      req_q   <= req_i.req_type;
      addr_q  <= req_i.address;
      cache_q <= req_i.target_is_cache;
    end
    if (load_hold) begin
      hold_red_q <= chain[HISTORY_DEPTH].match;
    end
    if (load_out) begin
      out_red_q <= (state_q == ST_HOLD) ? hold_red_q : chain[HISTORY_DEPTH].match;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.redundant = out_red_q;

  // cell chain
  always_comb begin
    chain[0].valid = launch;
    chain[0].match = (req_q == REQ_CHECK) && !cache_q;
  end

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    logic cmp_en;

    assign cmp_en         = check_cache && (CW'(entries_q) > CW'(i));
    assign probe_valid[i] = chain[i+1].valid;

    phf_cell #(
      .IW    (IW),
      .INDEX (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_en_i   (wr_en),
      .wr_slot_i (rem_q[IW-1:0]),
      .addr_i    (addr_q),
      .mask_i    (mask),
      .cmp_en_i  (cmp_en),
      .probe_i   (chain[i]),
      .probe_o   (chain[i+1])
    );
  end

  // assertions
  a_single_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(probe_valid))
    else $error("more than one probe in the cell chain");

  a_write_sets_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> last_valid_q)
    else $error("history write did not mark the last slot valid");

  a_launch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch |=> !req_i.ready)
    else $error("request accepted while a probe is walking");

  a_done_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (state_q == ST_WALK))
    else $error("probe left the chain outside the walk state");

endmodule
